// ----- src/etbm_pkg.sv -----
// Shared types and constants for the event trace buffer.
// Holds the stored entry layout, the match result bundle and the command and
// register codes. No dependencies.
`timescale 1ns / 1ps

package etbm_pkg;

  // Command codes
  localparam logic CMD_RECORD  = 1'b0;
  localparam logic CMD_INSPECT = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLETION_CODE = 2'd2;
  localparam int CFG_DATA_W = 8;

  // Field widths
  localparam int TIME_W  = 31;
  localparam int CODE_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int VALUE_W = 32;
  localparam int TAG_W   = 32;
  localparam int INDEX_W = 8;
  localparam int POS_W   = 9;

  // One stored trace entry
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [CODE_W-1:0]  code;
    logic [CHAN_W-1:0]  chan;
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Outcome of checking one candidate slot against the start entry
  typedef struct packed {
    logic              filled;
    logic              hit;
    logic [TIME_W-1:0] dur;
  } match_t;

endpackage

// ----- src/etbm_trace_mem.sv -----
// Trace entry store: one write port, one read port with registered data.
// Depends on etbm_pkg for the entry layout.
`timescale 1ns / 1ps

module etbm_trace_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  etbm_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output etbm_pkg::entry_t rdata
);
  import etbm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/etbm_match_unit.sv -----
// Shared compare/subtract unit used on every slot of a completion search.
// Depends on etbm_pkg for entry_t and match_t.
`timescale 1ns / 1ps

module etbm_match_unit (
  input  etbm_pkg::entry_t                     cand,
  input  logic [etbm_pkg::VALUE_W-1:0]         base_value,
  input  logic [etbm_pkg::TIME_W-1:0]          base_time,
  input  logic [etbm_pkg::CODE_W-1:0]          completion_code,
  output etbm_pkg::match_t                     res
);
  import etbm_pkg::*;

  // Unfilled slot ends the search; a hit needs code, key and a later time
  always_comb begin
    res.filled = (cand.stamp != '0);
    res.hit    = (cand.code == completion_code) && (cand.value == base_value) &&
                 (cand.stamp > base_time);
    res.dur    = cand.stamp - base_time;
  end

endmodule

// ----- src/event_trace_buffer_with_match.sv -----
// Top level of the event trace buffer: sequencer, configuration registers,
// result registers. Uses etbm_pkg, etbm_trace_mem and etbm_match_unit.
`timescale 1ns / 1ps
//
//  channel  | transfer when      | ports
//  ---------+--------------------+-----------------------------------------
//  input    | start && !busy     | in_command .. in_entry_index
//  result   | out_valid (1 cyc)  | out_write_position .. out_duration
//  config   | cfg_we             | cfg_index, cfg_data
//
//  Record: busy stays low; the result strobes on the next cycle.
//  Inspect: the inspected slot is read first; when it is a start entry the
//  search then reads the following slots, at most DEPTH - 1 of them, one per
//  cycle; busy stays high throughout and the result strobes as busy falls.
//  Reset: a clearing pass writes every slot to zero with busy high;
//  configuration writes are taken throughout.
//  The receiver cannot stall: each result is shown for exactly one cycle.

module event_trace_buffer_with_match #(
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_command,
  input  logic [etbm_pkg::CODE_W-1:0]           in_event_code,
  input  logic [etbm_pkg::CHAN_W-1:0]           in_channel_number,
  input  logic signed [etbm_pkg::VALUE_W-1:0]   in_event_value,
  input  logic [etbm_pkg::TAG_W-1:0]            in_event_tag,
  input  logic [etbm_pkg::TIME_W-1:0]           in_timestamp,
  input  logic [etbm_pkg::INDEX_W-1:0]          in_entry_index,
  // result channel
  output logic                                  out_valid,
  output logic [etbm_pkg::POS_W-1:0]            out_write_position,
  output logic                                  out_entry_filled,
  output logic [etbm_pkg::CODE_W-1:0]           out_entry_event,
  output logic [etbm_pkg::CHAN_W-1:0]           out_entry_channel,
  output logic signed [etbm_pkg::VALUE_W-1:0]   out_entry_value,
  output logic [etbm_pkg::TAG_W-1:0]            out_entry_tag,
  output logic [etbm_pkg::TIME_W-1:0]           out_entry_time,
  output logic                                  out_is_start,
  output logic                                  out_completion_found,
  output logic [etbm_pkg::INDEX_W-1:0]          out_completion_index,
  output logic [etbm_pkg::TIME_W-1:0]           out_completion_time,
  output logic [etbm_pkg::TIME_W-1:0]           out_duration,
  // configuration port
  input  logic                                  cfg_we,
  input  logic [etbm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [etbm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import etbm_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int PW  = $clog2(DEPTH + 1);
  localparam int MW  = 25;  // holds DEPTH << 7 for the largest depth
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BASE  = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  // Index reduction modulo DEPTH, restoring style over the 8 index bits
  function automatic logic [AW-1:0] idx_mod(input logic [INDEX_W-1:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    for (int k = INDEX_W - 1; k >= 0; k--) begin
      if (r >= (MW'(DEPTH) << k)) begin
        r = r - (MW'(DEPTH) << k);
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
    return (a == LAST_A) ? '0 : a + AW'(1);
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0]       next_slot_r, next_slot_nxt;
  logic [AW-1:0]       base_idx_r, base_idx_nxt;
  logic [AW-1:0]       chk_addr_r, chk_addr_nxt;
  logic [TIME_W-1:0]   base_time_r, base_time_nxt;
  logic [VALUE_W-1:0]  base_value_r, base_value_nxt;

  logic                wrap_enable_r;
  logic [CODE_W-1:0]   start_code_r;
  logic [CODE_W-1:0]   completion_code_r;

  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    wpos_r, wpos_nxt;
  logic                filled_r, filled_nxt;
  entry_t              ent_r, ent_nxt;
  logic                is_start_r, is_start_nxt;
  logic                found_r, found_nxt;
  logic [INDEX_W-1:0]  cidx_r, cidx_nxt;
  logic [TIME_W-1:0]   ctime_r, ctime_nxt;
  logic [TIME_W-1:0]   dur_r, dur_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  logic [AW-1:0]       mem_raddr;
  entry_t              mem_rdata;
  match_t              mres;
  logic                accept;
  logic [PW-1:0]       slot_inc;

  // Trace store
  etbm_trace_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared compare/subtract for the search
  etbm_match_unit u_match (
    .cand            (mem_rdata),
    .base_value      (base_value_r),
    .base_time       (base_time_r),
    .completion_code (completion_code_r),
    .res             (mres)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_enable_r     <= 1'b1;
      start_code_r      <= '0;
      completion_code_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRAP_ENABLE:     wrap_enable_r     <= cfg_data[0];
        CFG_START_CODE:      start_code_r      <= cfg_data;
        CFG_COMPLETION_CODE: completion_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = next_slot_r[AW-1:0];
    mem_wdata = '{stamp: in_timestamp, code: in_event_code, chan: in_channel_number,
                  value: in_event_value, tag: in_event_tag};
    mem_raddr = idx_mod(in_entry_index);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we = accept && (in_command == CMD_RECORD) && (next_slot_r < DEPTH_P);
      end
      ST_BASE: mem_raddr = inc_wrap(base_idx_r);
      ST_SCAN: mem_raddr = inc_wrap(chk_addr_r);
      default: ;
    endcase
  end

  // Write position after a record
  always_comb begin
    slot_inc = (next_slot_r < DEPTH_P) ? next_slot_r + PW'(1) : next_slot_r;
    if ((slot_inc >= DEPTH_P) && wrap_enable_r) begin
      slot_inc = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    next_slot_nxt  = next_slot_r;
    base_idx_nxt   = base_idx_r;
    chk_addr_nxt   = chk_addr_r;
    base_time_nxt  = base_time_r;
    base_value_nxt = base_value_r;
    out_valid_nxt  = 1'b0;
    wpos_nxt       = wpos_r;
    filled_nxt     = filled_r;
    ent_nxt        = ent_r;
    is_start_nxt   = is_start_r;
    found_nxt      = found_r;
    cidx_nxt       = cidx_r;
    ctime_nxt      = ctime_r;
    dur_nxt        = dur_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = inc_wrap(clr_cnt_r);
        if (clr_cnt_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_RECORD) begin
            next_slot_nxt = slot_inc;
            out_valid_nxt = 1'b1;
            wpos_nxt      = POS_W'(slot_inc);
            filled_nxt    = 1'b0;
            ent_nxt       = '0;
            is_start_nxt  = 1'b0;
            found_nxt     = 1'b0;
            cidx_nxt      = '0;
            ctime_nxt     = '0;
            dur_nxt       = '0;
          end else begin
            base_idx_nxt = idx_mod(in_entry_index);
            state_nxt    = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        // Inspected entry is on the read port
        base_time_nxt  = mem_rdata.stamp;
        base_value_nxt = mem_rdata.value;
        wpos_nxt       = POS_W'(next_slot_r);
        filled_nxt     = (mem_rdata.stamp != '0);
        ent_nxt        = mem_rdata;
        is_start_nxt   = (mem_rdata.code == start_code_r);
        found_nxt      = 1'b0;
        cidx_nxt       = '0;
        ctime_nxt      = '0;
        dur_nxt        = '0;
        if (mem_rdata.code == start_code_r) begin
          chk_addr_nxt = inc_wrap(base_idx_r);
          state_nxt    = ST_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Candidate at chk_addr_r is on the read port
        priority if (!mres.filled) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (mres.hit) begin
          found_nxt     = 1'b1;
          cidx_nxt      = INDEX_W'(chk_addr_r);
          ctime_nxt     = mem_rdata.stamp;
          dur_nxt       = mres.dur;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (inc_wrap(chk_addr_r) == base_idx_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          chk_addr_nxt = inc_wrap(chk_addr_r);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_slot_r <= next_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    base_idx_r   <= base_idx_nxt;
    chk_addr_r   <= chk_addr_nxt;
    base_time_r  <= base_time_nxt;
    base_value_r <= base_value_nxt;
    wpos_r       <= wpos_nxt;
    filled_r     <= filled_nxt;
    ent_r        <= ent_nxt;
    is_start_r   <= is_start_nxt;
    found_r      <= found_nxt;
    cidx_r       <= cidx_nxt;
    ctime_r      <= ctime_nxt;
    dur_r        <= dur_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_write_position   = wpos_r;
  assign out_entry_filled     = filled_r;
  assign out_entry_event      = ent_r.code;
  assign out_entry_channel    = ent_r.chan;
  assign out_entry_value      = $signed(ent_r.value);
  assign out_entry_tag        = ent_r.tag;
  assign out_entry_time       = ent_r.stamp;
  assign out_is_start         = is_start_r;
  assign out_completion_found = found_r;
  assign out_completion_index = cidx_r;
  assign out_completion_time  = ctime_r;
  assign out_duration         = dur_r;

  // Checks
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= DEPTH_P)
    else $error("write position beyond depth");

  a_record_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_RECORD)) |=> out_valid)
    else $error("record transfer gave no result");

  a_found_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_completion_found) |-> (out_is_start && (out_duration != '0)))
    else $error("completion without start or with zero duration");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (chk_addr_r != base_idx_r))
    else $error("search reached its own start slot");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_valid)
    else $error("result strobe during search");

endmodule
